/* src/eemu_pkg.sv */
// Shared types, opcodes, bit masks and vector table for the exception entry unit.
package eemu_pkg;

    // Operation codes carried by the opcode field.
    typedef enum logic [2:0] {
        OP_RAISE     = 3'd0,
        OP_TAKE      = 3'd1,
        OP_RFI       = 3'd2,
        OP_MT_WORD   = 3'd3,
        OP_MT_DWORD  = 3'd4,
        OP_READ      = 3'd5
    } opcode_t;

    localparam int EXC_COUNT = 14;
    localparam int EXC_IDX_W = 4;
    localparam int DATA_W    = 64;

    // Exception kinds by priority position in the pending set.
    localparam logic [EXC_IDX_W-1:0] EXC_SYSTEM_RESET = 4'd0;
    localparam logic [EXC_IDX_W-1:0] EXC_MACHINE_CHECK = 4'd1;

    // Architectural state kept by the unit.
    typedef struct packed {
        logic [DATA_W-1:0]    msr;
        logic [DATA_W-1:0]    save_address;
        logic [DATA_W-1:0]    save_state;
        logic [EXC_COUNT-1:0] pending;
    } eemu_state_t;

    // Fields of one result besides the state copies.
    typedef struct packed {
        logic [DATA_W-1:0] new_address;
        logic              vector_taken;
        logic              checkstop;
    } eemu_result_t;

    // Outcome of the pending-set priority search.
    typedef struct packed {
        logic                 found;
        logic [EXC_IDX_W-1:0] idx;
    } eemu_prio_t;

    // Mask of big-endian bits first..last (bit 0 is the most significant).
    function automatic logic [DATA_W-1:0] be_range(input int first, input int last);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int i = 0; i < DATA_W; i++) begin
            if (i >= first && i <= last) begin
                m[DATA_W-1-i] = 1'b1;
            end
        end
        return m;
    endfunction

    // Single-bit masks in big-endian numbering.
    localparam logic [DATA_W-1:0] B0  = be_range(0, 0);
    localparam logic [DATA_W-1:0] B1  = be_range(1, 1);
    localparam logic [DATA_W-1:0] B47 = be_range(47, 47);
    localparam logic [DATA_W-1:0] B49 = be_range(49, 49);
    localparam logic [DATA_W-1:0] B51 = be_range(51, 51);
    localparam logic [DATA_W-1:0] B58 = be_range(58, 58);
    localparam logic [DATA_W-1:0] B59 = be_range(59, 59);
    localparam logic [DATA_W-1:0] B63 = be_range(63, 63);

    // State bits saved on exception entry.
    localparam logic [DATA_W-1:0] TAKE_SAVE_MASK =
        B0 | be_range(48, 55) | be_range(57, 59) | be_range(62, 63);
    // State bits cleared on exception entry.
    localparam logic [DATA_W-1:0] TAKE_CLEAR_MASK =
        be_range(45, 45) | be_range(48, 50) | be_range(52, 55) | B58 | B59
        | be_range(61, 62);
    // Save register bits cleared by a system reset.
    localparam logic [DATA_W-1:0] SRESET_CLEAR_MASK = be_range(33, 36) | be_range(42, 47);
    // Bits restored directly by return from interrupt.
    localparam logic [DATA_W-1:0] RFI_COPY_MASK =
        be_range(1, 2) | be_range(4, 32) | be_range(37, 41) | be_range(52, 58)
        | be_range(60, 63);
    // Bits copied by the move-to forms.
    localparam logic [DATA_W-1:0] MT_SHORT_MASK = be_range(48, 62);
    localparam logic [DATA_W-1:0] MT_COMMON_MASK =
        be_range(49, 50) | be_range(52, 57) | be_range(60, 63);
    localparam logic [DATA_W-1:0] MT_WORD_MASK  = MT_COMMON_MASK | be_range(32, 47);
    localparam logic [DATA_W-1:0] MT_DWORD_MASK =
        MT_COMMON_MASK | be_range(1, 2) | be_range(4, 47);

    // Fixed vector address of each exception kind.
    function automatic logic [DATA_W-1:0] vector_addr(input logic [EXC_IDX_W-1:0] idx);
        logic [DATA_W-1:0] v;
        unique case (idx)
            4'd0:    v = 64'h100;
            4'd1:    v = 64'h200;
            4'd2:    v = 64'hC00;
            4'd3:    v = 64'h800;
            4'd4:    v = 64'h700;
            4'd5:    v = 64'h300;
            4'd6:    v = 64'h380;
            4'd7:    v = 64'h600;
            4'd8:    v = 64'hD00;
            4'd9:    v = 64'h400;
            4'd10:   v = 64'h480;
            4'd11:   v = 64'h500;
            4'd12:   v = 64'h900;
            4'd13:   v = 64'hF00;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* src/exception_entry_and_msr_unit.sv */
// Top level: input register, state registers and result register.
// Datapath: an accepted item is held in the input register, passes through the
// combinational next-state logic, and its result is captured in the result register.
// Throughput: one item per cycle while out_ready stays high; the single pass of
// bit copies and the 14-way priority encoder sets the cycle.
// Reset: rst_n clears the state word, both save registers and the pending set.
module exception_entry_and_msr_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     opcode,
    input  logic [eemu_pkg::DATA_W-1:0]    current_address,
    input  logic [eemu_pkg::DATA_W-1:0]    source_value,
    input  logic                           l_flag,
    input  logic [eemu_pkg::EXC_COUNT-1:0] raise_mask,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [eemu_pkg::DATA_W-1:0]    new_address,
    output logic                           vector_taken,
    output logic                           checkstop,
    output logic [eemu_pkg::DATA_W-1:0]    read_value,
    output logic [eemu_pkg::DATA_W-1:0]    saved_address,
    output logic [eemu_pkg::DATA_W-1:0]    saved_state
);
    import eemu_pkg::*;

    logic                 in_valid_reg;
    opcode_t              op_reg;
    logic [DATA_W-1:0]    addr_reg;
    logic [DATA_W-1:0]    src_reg;
    logic                 lflag_reg;
    logic [EXC_COUNT-1:0] mask_reg;

    eemu_state_t          state_reg;
    eemu_state_t          state_next;
    eemu_result_t         result_next;

    logic                 out_valid_reg;
    eemu_result_t         result_reg;
    eemu_state_t          out_state_reg;

    logic                 proc_fire;
    logic                 in_fire;

    // Handshake: the input stage advances when the result stage is free or draining.
    assign proc_fire = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || proc_fire;
    assign in_fire   = in_valid && in_ready;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            op_reg    <= opcode_t'(opcode);
            addr_reg  <= current_address;
            src_reg   <= source_value;
            lflag_reg <= l_flag;
            mask_reg  <= raise_mask;
        end
    end

    eemu_next_state u_next (
        .state_cur       (state_reg),
        .opcode          (op_reg),
        .current_address (addr_reg),
        .source_value    (src_reg),
        .l_flag          (lflag_reg),
        .raise_mask      (mask_reg),
        .state_nxt       (state_next),
        .result          (result_next)
    );

    // Architectural state updates once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
        end else if (proc_fire) begin
            state_reg <= state_next;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (proc_fire) begin
            result_reg    <= result_next;
            out_state_reg <= state_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign new_address   = result_reg.new_address;
    assign vector_taken  = result_reg.vector_taken;
    assign checkstop     = result_reg.checkstop;
    assign read_value    = out_state_reg.msr;
    assign saved_address = out_state_reg.save_address;
    assign saved_state   = out_state_reg.save_state;

    // A take never both vectors and checkstops.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(result_reg.vector_taken && result_reg.checkstop))
        else $error("vector and checkstop reported together");

    // Vector addresses all lie in the low page.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.vector_taken) |-> (result_reg.new_address[63:12] == '0))
        else $error("vector address out of range");

    // Only a raise can add pending flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && op_reg != OP_RAISE)
        |=> ((state_reg.pending & ~$past(state_reg.pending)) == '0))
        else $error("pending flag appeared without a raise");

    // A reported result matches the state that was committed with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire |=> (out_state_reg == state_reg))
        else $error("result state differs from committed state");

    // The input stage is stalled only while it holds an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg)
        else $error("input stalled while empty");

endmodule

/* src/eemu_prio_enc.sv */
// Fixed-priority encoder over the pending exception flags.
module eemu_prio_enc (
    input  logic [eemu_pkg::EXC_COUNT-1:0] pending,
    output eemu_pkg::eemu_prio_t           prio
);
    import eemu_pkg::*;

    // Lowest set bit wins; scan from the top so the last hit is the winner.
    always_comb
    begin
        prio.found = |pending;
        prio.idx   = '0;
        for (int k = EXC_COUNT - 1; k >= 0; k--) begin
            if (pending[k]) begin
                prio.idx = EXC_IDX_W'(k);
            end
        end
    end

endmodule

/* src/eemu_next_state.sv */
// Combinational next-state and result logic for one operation.
module eemu_next_state (
    input  eemu_pkg::eemu_state_t          state_cur,
    input  eemu_pkg::opcode_t              opcode,
    input  logic [eemu_pkg::DATA_W-1:0]    current_address,
    input  logic [eemu_pkg::DATA_W-1:0]    source_value,
    input  logic                           l_flag,
    input  logic [eemu_pkg::EXC_COUNT-1:0] raise_mask,
    output eemu_pkg::eemu_state_t          state_nxt,
    output eemu_pkg::eemu_result_t         result
);
    import eemu_pkg::*;

    eemu_prio_t        prio;
    logic [DATA_W-1:0] msr;
    logic [DATA_W-1:0] srr1;
    logic [DATA_W-1:0] take_msr;
    logic [DATA_W-1:0] rfi_msr;
    logic [DATA_W-1:0] mt_msr;
    logic [DATA_W-1:0] mt_mask;
    logic              mce;

    eemu_prio_enc u_prio (
        .pending (state_cur.pending),
        .prio    (prio)
    );

    assign msr  = state_cur.msr;
    assign srr1 = state_cur.save_state;
    assign mce  = |(msr & B51);

    // State word after exception entry, before the machine-check adjustment.
    always_comb
    begin
        take_msr = (msr | B0) & ~TAKE_CLEAR_MASK;
        take_msr = (take_msr & ~B63) | ({DATA_W{|(msr & B47)}} & B63);
    end

    // Return from interrupt: two merged bits, then the copied ranges.
    always_comb
    begin
        rfi_msr = msr;
        rfi_msr = (rfi_msr & ~B0) | ({DATA_W{|(srr1 & (B0 | B1))}} & B0);
        rfi_msr = (rfi_msr & ~B59) | ({DATA_W{|(srr1 & (B59 | B49))}} & B59);
        rfi_msr = (rfi_msr & ~RFI_COPY_MASK) | (srr1 & RFI_COPY_MASK);
    end

    // Move-to in long and short forms.
    always_comb
    begin
        mt_msr  = msr;
        mt_mask = MT_WORD_MASK;
        if (l_flag) begin
            mt_msr = (msr & ~MT_SHORT_MASK) | (source_value & MT_SHORT_MASK);
        end else begin
            mt_msr = (mt_msr & ~B58)
                   | ({DATA_W{|(source_value & (B58 | B49))}} & B58);
            mt_msr = (mt_msr & ~B59)
                   | ({DATA_W{|(source_value & (B59 | B49))}} & B59);
            if (opcode == OP_MT_DWORD) begin
                mt_msr  = (mt_msr & ~B0)
                        | ({DATA_W{|(source_value & (B0 | B1))}} & B0);
                mt_mask = MT_DWORD_MASK;
            end
            mt_msr = (mt_msr & ~mt_mask) | (source_value & mt_mask);
        end
    end

    // Operation select.
    always_comb
    begin
        state_nxt          = state_cur;
        result.new_address = current_address;
        result.vector_taken = 1'b0;
        result.checkstop   = 1'b0;
        unique case (opcode)
            OP_RAISE: begin
                state_nxt.pending = state_cur.pending | raise_mask;
            end
            OP_TAKE: begin
                if (prio.found) begin
                    state_nxt.save_state   = (srr1 & ~TAKE_SAVE_MASK)
                                           | (msr & TAKE_SAVE_MASK);
                    state_nxt.msr          = take_msr;
                    state_nxt.save_address = current_address;
                    state_nxt.pending      = state_cur.pending
                                           & ~(EXC_COUNT'(1) << prio.idx);
                    if (prio.idx == EXC_SYSTEM_RESET) begin
                        state_nxt.save_state = state_nxt.save_state & ~SRESET_CLEAR_MASK;
                    end
                    if (prio.idx == EXC_MACHINE_CHECK && !mce) begin
                        result.checkstop = 1'b1;
                    end else begin
                        if (prio.idx == EXC_MACHINE_CHECK) begin
                            state_nxt.msr = take_msr & ~B51;
                        end
                        result.new_address  = vector_addr(prio.idx);
                        result.vector_taken = 1'b1;
                    end
                end
            end
            OP_RFI: begin
                state_nxt.msr = rfi_msr;
            end
            OP_MT_WORD, OP_MT_DWORD: begin
                state_nxt.msr = mt_msr;
            end
            OP_READ: begin
                state_nxt = state_cur;
            end
            default: begin
                state_nxt = state_cur;
            end
        endcase
    end

endmodule
